>>> rtl/core/swf_trp_pkg.sv
package swf_trp_pkg;

	// bit buffer holds at most 31 leftover bits plus one new byte
	localparam int BUF_W = 40;
	localparam int CNT_W = 6;
	localparam int WID_W = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_GLYPH  = 2'd1;
	localparam logic [1:0] KIND_END    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_INDEX_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_BITS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_HAS_ALPHA  = 2'd2;

	typedef struct packed {
		logic       is_start;
		logic [7:0] data;
	} op_t;

	typedef struct packed {
		logic [WID_W-1:0] index_bits;
		logic [WID_W-1:0] advance_bits;
		logic             has_alpha;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  present_mask;
		logic [15:0] font_id;
		logic [31:0] color_rgba;
		logic [15:0] x_offset;
		logic [15:0] y_offset;
		logic [15:0] text_height;
		logic [7:0]  glyph_count;
		logic [31:0] glyph_index;
		logic [31:0] glyph_advance;
		logic        last;
	} result_t;

	function automatic logic [WID_W-1:0] clamp_width(logic [WID_W-1:0] w);
		if (w == '0)
			return WID_W'(1);
		if (w > WID_W'(32))
			return WID_W'(32);
		return w;
	endfunction

	function automatic logic [31:0] field_mask(logic [WID_W-1:0] w);
		logic [32:0] one;
		one = 33'd1;
		return 32'((one << w) - one);
	endfunction

	function automatic logic [BUF_W-1:0] buf_mask(logic [CNT_W-1:0] n);
		logic [BUF_W:0] one;
		one = (BUF_W+1)'(1);
		return BUF_W'((one << n) - one);
	endfunction

endpackage

>>> rtl/core/swf_trp_front.sv
module swf_trp_front #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               command,
	input  logic [7:0]         data_byte,
	output swf_trp_pkg::op_t   op,
	output logic               op_valid,
	input  logic               op_pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	swf_trp_pkg::op_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr_en, rd_en;
	swf_trp_pkg::op_t op_in;

	assign full     = (count_q == CW'(DEPTH));
	assign op_valid = (count_q != '0);
	assign wr_en    = push && !full;
	assign rd_en    = op_pop && op_valid;
	assign op       = mem_q[rd_ptr_q];

	// a start command is marked so the parser drops its byte
	always_comb begin
		op_in.is_start = command;
		op_in.data     = data_byte;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= op_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + CW'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> rtl/core/swf_trp_back.sv
module swf_trp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swf_trp_pkg::cfg_t    cfg,
	input  swf_trp_pkg::op_t     op,
	input  logic                 op_valid,
	output logic                 op_pop,
	input  logic                 out_full,
	output logic                 res_wr,
	output swf_trp_pkg::result_t res
);

	typedef enum logic [3:0] {
		PH_FLAGS,
		PH_FONT,
		PH_COLOR,
		PH_X,
		PH_Y,
		PH_HEIGHT,
		PH_COUNT,
		PH_GLYPHS,
		PH_STOP
	} phase_t;

	phase_t phase_q;
	logic        run_q;
	logic [3:0]  flags_q;
	logic [2:0]  fbi_q;
	logic [15:0] font_q, x_q, y_q, height_q;
	logic [31:0] color_q;
	logic [7:0]  total_q, left_q;
	logic [swf_trp_pkg::BUF_W-1:0] buf_q;
	logic [swf_trp_pkg::CNT_W-1:0] cnt_q;
	logic        held_q;
	logic [31:0] held_idx_q;
	logic [1:0]  nglyph_q;

	logic [swf_trp_pkg::WID_W-1:0] wi, wa;
	logic [4:0]  wa_m1;
	logic [swf_trp_pkg::CNT_W-1:0] rem, idx_sh, adv_sh, cnt_after;
	logic        has_idx, has_adv;
	logic [31:0] idx_raw, adv_raw, adv_ext, glyph_idx;
	logic        step;
	logic [swf_trp_pkg::BUF_W-1:0] buf_app;
	logic [31:0] color_n;
	logic [2:0]  fbi_inc;
	logic        color_done;

	function automatic phase_t next_phase(phase_t cur, logic [3:0] fl);
		if (cur < PH_FONT && fl[3])
			return PH_FONT;
		if (cur < PH_COLOR && fl[2])
			return PH_COLOR;
		if (cur < PH_X && fl[0])
			return PH_X;
		if (cur < PH_Y && fl[1])
			return PH_Y;
		if (cur < PH_HEIGHT && fl[3])
			return PH_HEIGHT;
		return PH_COUNT;
	endfunction

	assign wi = swf_trp_pkg::clamp_width(cfg.index_bits);
	assign wa = swf_trp_pkg::clamp_width(cfg.advance_bits);

	// glyph extraction: bits are right aligned, the oldest bit at cnt_q-1
	always_comb begin
		has_idx   = held_q || (cnt_q >= wi);
		rem       = held_q ? cnt_q : cnt_q - wi;
		has_adv   = has_idx && (rem >= wa);
		idx_sh    = cnt_q - wi;
		adv_sh    = rem - wa;
		cnt_after = has_adv ? adv_sh : rem;
		idx_raw   = 32'(buf_q >> idx_sh) & swf_trp_pkg::field_mask(wi);
		adv_raw   = 32'(buf_q >> adv_sh) & swf_trp_pkg::field_mask(wa);
		wa_m1     = 5'(wa - swf_trp_pkg::WID_W'(1));
		adv_ext   = adv_raw[wa_m1] ? (adv_raw | ~swf_trp_pkg::field_mask(wa)) : adv_raw;
		glyph_idx = held_q ? held_idx_q : idx_raw;
		buf_app   = {buf_q[swf_trp_pkg::BUF_W-9:0], op.data};
	end

	always_comb begin
		color_n = color_q;
		case (fbi_q[1:0])
			2'd0: color_n[31:24] = op.data;
			2'd1: color_n[23:16] = op.data;
			2'd2: color_n[15:8]  = op.data;
			default: color_n[7:0] = op.data;
		endcase
		fbi_inc    = fbi_q + 3'd1;
		color_done = fbi_inc >= (cfg.has_alpha ? 3'd4 : 3'd3);
		if (color_done && !cfg.has_alpha)
			color_n[7:0] = 8'hFF;
	end

	assign op_pop = !run_q && op_valid && !out_full;
	assign step   = run_q && !out_full;

	always_comb begin
		res_wr            = 1'b0;
		res.kind          = swf_trp_pkg::KIND_GLYPH;
		res.present_mask  = flags_q;
		res.font_id       = font_q;
		res.color_rgba    = color_q;
		res.x_offset      = x_q;
		res.y_offset      = y_q;
		res.text_height   = height_q;
		res.glyph_count   = total_q;
		res.glyph_index   = glyph_idx;
		res.glyph_advance = adv_ext;
		res.last          = (left_q == 8'd1);
		if (op_pop && !op.is_start && phase_q == PH_FLAGS && op.data == 8'd0) begin
			res_wr = 1'b1;
			res    = '0;
			res.kind = swf_trp_pkg::KIND_END;
		end else if (op_pop && !op.is_start && phase_q == PH_COUNT) begin
			res_wr            = 1'b1;
			res.kind          = swf_trp_pkg::KIND_HEADER;
			res.glyph_count   = op.data;
			res.glyph_index   = '0;
			res.glyph_advance = '0;
			res.last          = 1'b0;
		end else if (step && has_adv) begin
			res_wr = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FLAGS;
			run_q      <= 1'b0;
			flags_q    <= '0;
			fbi_q      <= '0;
			font_q     <= '0;
			color_q    <= '0;
			x_q        <= '0;
			y_q        <= '0;
			height_q   <= '0;
			total_q    <= '0;
			left_q     <= '0;
			buf_q      <= '0;
			cnt_q      <= '0;
			held_q     <= 1'b0;
			held_idx_q <= '0;
			nglyph_q   <= '0;
		end else if (op_pop) begin
			if (op.is_start) begin
				phase_q    <= PH_FLAGS;
				fbi_q      <= '0;
				left_q     <= '0;
				buf_q      <= '0;
				cnt_q      <= '0;
				held_q     <= 1'b0;
				held_idx_q <= '0;
			end else begin
				case (phase_q)
					PH_FLAGS: begin
						flags_q <= op.data[3:0];
						fbi_q   <= '0;
						if (op.data == 8'd0)
							phase_q <= PH_STOP;
						else
							phase_q <= next_phase(PH_FLAGS, op.data[3:0]);
					end
					PH_FONT, PH_X, PH_Y, PH_HEIGHT: begin
						case (phase_q)
							PH_FONT: font_q <= (fbi_q == '0) ? {8'h00, op.data} : {op.data, font_q[7:0]};
							PH_X: x_q <= (fbi_q == '0) ? {8'h00, op.data} : {op.data, x_q[7:0]};
							PH_Y: y_q <= (fbi_q == '0) ? {8'h00, op.data} : {op.data, y_q[7:0]};
							default: height_q <= (fbi_q == '0) ? {8'h00, op.data} :
								{op.data, height_q[7:0]};
						endcase
						if (fbi_q != '0) begin
							phase_q <= next_phase(phase_q, flags_q);
							fbi_q   <= '0;
						end else begin
							fbi_q <= fbi_inc;
						end
					end
					PH_COLOR: begin
						color_q <= color_n;
						if (color_done) begin
							phase_q <= next_phase(PH_COLOR, flags_q);
							fbi_q   <= '0;
						end else begin
							fbi_q <= fbi_inc;
						end
					end
					PH_COUNT: begin
						total_q    <= op.data;
						left_q     <= op.data;
						buf_q      <= '0;
						cnt_q      <= '0;
						held_q     <= 1'b0;
						held_idx_q <= '0;
						fbi_q      <= '0;
						phase_q    <= (op.data == 8'd0) ? PH_STOP : PH_GLYPHS;
					end
					PH_GLYPHS: begin
						buf_q    <= buf_app;
						cnt_q    <= cnt_q + swf_trp_pkg::CNT_W'(8);
						run_q    <= 1'b1;
						nglyph_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end else if (step) begin
			if (has_adv) begin
				left_q   <= left_q - 8'd1;
				nglyph_q <= nglyph_q + 2'd1;
				held_q   <= 1'b0;
				if (left_q == 8'd1) begin
					// record done: leftover bits are dropped
					buf_q      <= '0;
					cnt_q      <= '0;
					held_idx_q <= '0;
					phase_q    <= PH_FLAGS;
					fbi_q      <= '0;
					run_q      <= 1'b0;
				end else begin
					buf_q <= buf_q & swf_trp_pkg::buf_mask(cnt_after);
					cnt_q <= cnt_after;
					if (nglyph_q == 2'd3)
						run_q <= 1'b0;
				end
			end else begin
				if (has_idx && !held_q) begin
					held_q     <= 1'b1;
					held_idx_q <= idx_raw;
					buf_q      <= buf_q & swf_trp_pkg::buf_mask(cnt_after);
					cnt_q      <= cnt_after;
				end
				run_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/swf_trp_outq.sv
module swf_trp_outq #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  swf_trp_pkg::result_t wr_data,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output swf_trp_pkg::result_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	swf_trp_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr_en, rd_en;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_en   = wr && !full;
	assign rd_en   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + CW'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> rtl/core/swf_text_record_parser.sv
// text record stream parser
// input: one word per push (command, data_byte), taken while full is low;
// command 1 restarts parsing at a flags byte and its byte is dropped.
// output: a queue of result words (header, glyph entry, end of records),
// the oldest shown while empty is low and removed by pop.
// config: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while no word is in flight.
// path: a header or end word is registered in the input queue, then written to the
// result queue; a glyph entry passes the input queue, the bit buffer and the result
// queue in that order.
// flow: the parser takes header and field bytes from the input queue while the result
// queue is not full; a glyph byte first loads the bit buffer, then the extractor gives
// one glyph entry per cycle while the result queue is not full (up to four per byte),
// with an extra step when its bits run out before the record or the fourth entry is done.
// the parser takes no new byte during this; the input queue keeps taking words meanwhile.
// reset: queues empty, parser waits for a flags byte, widths 8, RGB colour.
// when pop stays low the result queue fills, the parser stalls, then the
// input queue fills and full rises; nothing is lost.
module swf_text_record_parser #(
	parameter int IN_DEPTH  = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                command,
	input  logic [7:0]                          data_byte,
	output logic                                empty,
	input  logic                                pop,
	output logic [1:0]                          kind,
	output logic [3:0]                          present_mask,
	output logic [15:0]                         font_id,
	output logic [31:0]                         color_rgba,
	output logic signed [15:0]                  x_offset,
	output logic signed [15:0]                  y_offset,
	output logic [15:0]                         text_height,
	output logic [7:0]                          glyph_count,
	output logic [31:0]                         glyph_index,
	output logic signed [31:0]                  glyph_advance,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swf_trp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swf_trp_pkg::WID_W-1:0]       cfg_data
);

	swf_trp_pkg::cfg_t    cfg_q;
	swf_trp_pkg::op_t     op;
	swf_trp_pkg::result_t res, res_out;
	logic op_valid, op_pop, out_full, res_wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_bits   <= swf_trp_pkg::WID_W'(8);
			cfg_q.advance_bits <= swf_trp_pkg::WID_W'(8);
			cfg_q.has_alpha    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				swf_trp_pkg::REG_GLYPH_INDEX_BITS: cfg_q.index_bits <= cfg_data;
				swf_trp_pkg::REG_ADVANCE_BITS: cfg_q.advance_bits <= cfg_data;
				swf_trp_pkg::REG_COLOR_HAS_ALPHA: cfg_q.has_alpha <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	swf_trp_front #(
		.DEPTH(IN_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.command  (command),
		.data_byte(data_byte),
		.op       (op),
		.op_valid (op_valid),
		.op_pop   (op_pop)
	);

	swf_trp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.op      (op),
		.op_valid(op_valid),
		.op_pop  (op_pop),
		.out_full(out_full),
		.res_wr  (res_wr),
		.res     (res)
	);

	swf_trp_outq #(
		.DEPTH(OUT_DEPTH)
	) u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wr_data(res),
		.full   (out_full),
		.empty  (empty),
		.pop    (pop),
		.rd_data(res_out)
	);

	assign kind          = res_out.kind;
	assign present_mask  = res_out.present_mask;
	assign font_id       = res_out.font_id;
	assign color_rgba    = res_out.color_rgba;
	assign x_offset      = res_out.x_offset;
	assign y_offset      = res_out.y_offset;
	assign text_height   = res_out.text_height;
	assign glyph_count   = res_out.glyph_count;
	assign glyph_index   = res_out.glyph_index;
	assign glyph_advance = res_out.glyph_advance;
	assign last          = res_out.last;

endmodule
